// ===== sv/twcc_pkg.sv =====
// Shared types and constants for the text window cursor controller.
// No dependencies; imported by every module of the block.
package twcc_pkg;

    localparam int SCREEN_COLS = 40;
    localparam int SCREEN_ROWS = 25;

    localparam logic [7:0] CODE_CLEAR     = 8'hFF;
    localparam logic [7:0] CODE_UNDERLINE = 8'hFE;
    localparam logic [7:0] CODE_INVERSE   = 8'hFD;
    localparam logic [7:0] CODE_CENTER_ON = 8'hFC;
    localparam logic [7:0] CODE_CENTER_OFF = 8'hFB;
    localparam logic [6:0] LOW_MASK       = 7'h7F;
    localparam logic [6:0] CODE_NEWLINE   = 7'h0A;
    localparam logic [6:0] CODE_RETURN    = 7'h0D;

    localparam logic [7:0] REG_WIN_LEFT     = 8'd0;
    localparam logic [7:0] REG_WIN_TOP      = 8'd1;
    localparam logic [7:0] REG_WIN_RIGHT    = 8'd2;
    localparam logic [7:0] REG_WIN_BOTTOM   = 8'd3;
    localparam logic [7:0] REG_AUTO_ADVANCE = 8'd4;

    localparam logic       FUNC_PUT_CHAR = 1'b0;

    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
        logic [7:0] pos_col;
        logic [7:0] pos_row;
    } item_t;

    typedef struct packed {
        logic [5:0] win_left;
        logic [4:0] win_top;
        logic [5:0] win_right;
        logic [4:0] win_bottom;
        logic       auto_advance;
    } cfg_t;

    typedef struct packed {
        logic [5:0] col;
        logic [4:0] row;
        logic       underline;
        logic       inverse;
        logic       center;
    } cursor_state_t;

    typedef struct packed {
        logic       draw_en;
        logic [7:0] glyph_code;
        logic [5:0] draw_col;
        logic [4:0] draw_row;
        logic       underline_on;
        logic       inverse_on;
        logic       center_on;
        logic       clear_en;
        logic       scroll_en;
        logic [5:0] cursor_col;
        logic [4:0] cursor_row;
    } result_t;

    typedef struct packed {
        logic [4:0] row;
        logic       scroll;
    } line_feed_t;

    // Bottom check after a line move: one pull-back at most.
    function automatic line_feed_t line_feed(input logic [5:0] row,
                                             input logic [4:0] top,
                                             input logic [4:0] bottom);
        line_feed_t lf;
        lf.scroll = ((7'(row) + 7'(top)) > 7'(bottom));
        if (!lf.scroll)
        begin
            lf.row = row[4:0];
        end
        else if (row != 6'd0)
        begin
            lf.row = 5'(row - 6'd1);
        end
        else
        begin
            lf.row = 5'd0;
        end
        return lf;
    endfunction

endpackage

// ===== sv/twcc_cfg.sv =====
// Window configuration registers written over the configuration channel.
// Depends on twcc_pkg.
module twcc_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output twcc_pkg::cfg_t    cfg
);
    import twcc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_left     <= 6'd0;
            cfg_reg.win_top      <= 5'd0;
            cfg_reg.win_right    <= 6'd39;
            cfg_reg.win_bottom   <= 5'd24;
            cfg_reg.auto_advance <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIN_LEFT:     cfg_reg.win_left     <= cfg_data[5:0];
                REG_WIN_TOP:      cfg_reg.win_top      <= cfg_data[4:0];
                REG_WIN_RIGHT:    cfg_reg.win_right    <= cfg_data[5:0];
                REG_WIN_BOTTOM:   cfg_reg.win_bottom   <= cfg_data[4:0];
                REG_AUTO_ADVANCE: cfg_reg.auto_advance <= cfg_data[0];
                default:          ;
            endcase
        end
    end
endmodule

// ===== sv/twcc_in_reg.sv =====
// Input register stage holding one accepted request.
// Depends on twcc_pkg.
module twcc_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             drain,
    input  twcc_pkg::item_t  item_in,
    output logic             item_valid,
    output twcc_pkg::item_t  item_out
);
    import twcc_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (drain)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end
endmodule

// ===== sv/twcc_step.sv =====
// Single-pass decode of one request against cursor state and window setup.
// Depends on twcc_pkg.
module twcc_step (
    input  twcc_pkg::item_t         item,
    input  twcc_pkg::cfg_t          cfg,
    input  twcc_pkg::cursor_state_t state,
    output twcc_pkg::cursor_state_t state_next,
    output twcc_pkg::result_t       result
);
    import twcc_pkg::*;

    logic [6:0] low_code;
    logic [6:0] col_inc;
    logic [6:0] col_edge;
    logic       pos_ok;
    line_feed_t lf_nl;
    line_feed_t lf_cr;

    assign low_code = item.char_code[6:0] & LOW_MASK;
    assign col_inc  = 7'(state.col) + 7'd1;
    assign col_edge = col_inc + 7'(cfg.win_left);
    assign pos_ok   = ((9'(item.pos_col) + 9'(cfg.win_left)) < 9'(SCREEN_COLS)) &&
                      ((9'(item.pos_row) + 9'(cfg.win_top)) < 9'(SCREEN_ROWS));
    assign lf_nl    = line_feed(6'(state.row) + 6'd1, cfg.win_top, cfg.win_bottom);
    assign lf_cr    = line_feed(6'(state.row), cfg.win_top, cfg.win_bottom);

    always_comb
    begin
        state_next = state;
        result     = '0;
        if (item.func != FUNC_PUT_CHAR)
        begin
            if (pos_ok)
            begin
                state_next.col = item.pos_col[5:0];
                state_next.row = item.pos_row[4:0];
            end
        end
        else
        begin
            priority if (item.char_code == CODE_CLEAR)
            begin
                state_next.col  = 6'd0;
                state_next.row  = 5'd0;
                result.clear_en = 1'b1;
            end
            else if (item.char_code == CODE_UNDERLINE)
            begin
                state_next.underline = ~state.underline;
            end
            else if (item.char_code == CODE_INVERSE)
            begin
                state_next.inverse = ~state.inverse;
            end
            else if (item.char_code == CODE_CENTER_ON)
            begin
                state_next.center = 1'b1;
            end
            else if (item.char_code == CODE_CENTER_OFF)
            begin
                state_next.center = 1'b0;
            end
            else if (low_code == CODE_NEWLINE)
            begin
                state_next.col   = 6'd0;
                state_next.row   = lf_nl.row;
                result.scroll_en = lf_nl.scroll;
            end
            else if (low_code == CODE_RETURN)
            begin
                state_next.col   = 6'd0;
                state_next.row   = lf_cr.row;
                result.scroll_en = lf_cr.scroll;
            end
            else
            begin
                result.draw_en      = 1'b1;
                result.glyph_code   = item.char_code;
                result.draw_col     = state.col + cfg.win_left;
                result.draw_row     = state.row + cfg.win_top;
                result.underline_on = state.underline;
                result.inverse_on   = state.inverse;
                if (cfg.auto_advance)
                begin
                    if (col_edge > 7'(cfg.win_right))
                    begin
                        state_next.col   = 6'd0;
                        state_next.row   = lf_nl.row;
                        result.scroll_en = lf_nl.scroll;
                    end
                    else
                    begin
                        state_next.col = col_inc[5:0];
                    end
                end
            end
        end
        result.center_on  = state_next.center;
        result.cursor_col = state_next.col;
        result.cursor_row = state_next.row;
    end
endmodule

// ===== sv/text_window_cursor_control.sv =====
// Text window cursor controller: top level with cursor state and result register.
// Depends on twcc_pkg, twcc_cfg, twcc_in_reg and twcc_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: a character byte
//   (func 0) or a set-cursor request (func 1). Every request yields exactly one
//   result on the output channel (out_valid/out_ready).
//   Configuration channel (cfg_valid/cfg_ready) writes the window registers by
//   index; it is always ready and should only be used while no request is in
//   flight.
//   A request is registered in the input register, then decoded against the
//   cursor state into the result register. Throughput: one request per cycle
//   while the receiver keeps out_ready high, set by the cursor update loop.
//   When the receiver stalls, the result register holds and the input register
//   holds one more request; in_ready drops only when both are full.
//   Reset clears the cursor and effect flags, empties both stages and loads the
//   window registers with their defaults (full 40 by 25 screen, auto-advance on).
module text_window_cursor_control (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] char_code,
    input  logic [7:0] pos_col,
    input  logic [7:0] pos_row,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       draw_en,
    output logic [7:0] glyph_code,
    output logic [5:0] draw_col,
    output logic [4:0] draw_row,
    output logic       underline_on,
    output logic       inverse_on,
    output logic       center_on,
    output logic       clear_en,
    output logic       scroll_en,
    output logic [5:0] cursor_col,
    output logic [4:0] cursor_row
);
    import twcc_pkg::*;

    cfg_t          cfg;
    item_t         in_item;
    item_t         s1_item;
    logic          s1_valid;
    logic          advance;
    logic          load;
    cursor_state_t state_reg;
    cursor_state_t state_next;
    result_t       step_result;
    result_t       result_reg;
    logic          out_valid_reg;

    assign in_item   = '{func: func, char_code: char_code, pos_col: pos_col, pos_row: pos_row};
    assign advance   = s1_valid && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid || advance;
    assign load      = in_valid && in_ready;

    twcc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    twcc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .drain      (advance),
        .item_in    (in_item),
        .item_valid (s1_valid),
        .item_out   (s1_item)
    );

    twcc_step u_step (
        .item       (s1_item),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign draw_en      = result_reg.draw_en;
    assign glyph_code   = result_reg.glyph_code;
    assign draw_col     = result_reg.draw_col;
    assign draw_row     = result_reg.draw_row;
    assign underline_on = result_reg.underline_on;
    assign inverse_on   = result_reg.inverse_on;
    assign center_on    = result_reg.center_on;
    assign clear_en     = result_reg.clear_en;
    assign scroll_en    = result_reg.scroll_en;
    assign cursor_col   = result_reg.cursor_col;
    assign cursor_row   = result_reg.cursor_row;
endmodule
